FILE: design/c8ic_pkg.sv
`timescale 1ns / 1ps
package c8ic_pkg;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_FX   = 2'd1;
    localparam logic [1:0] ST_LOAD_OVF = 2'd2;

    localparam logic [11:0] PC_RESET  = 12'h200;
    localparam logic [12:0] PROG_BASE = 13'd512;
    localparam int          FONT_LEN  = 80;

    // datapath operations, one per controller step
    typedef enum logic [3:0] {
        DP_NONE,
        DP_CLEAR,
        DP_TAKE,
        DP_LOAD,
        DP_FETCH_HI,
        DP_FETCH_LO,
        DP_READ_Y,
        DP_EXEC,
        DP_WR_VF,
        DP_WR_VX,
        DP_ST_RD,
        DP_ST_WR,
        DP_LD_RD,
        DP_LD_WR
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   publish;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic need_vf;
        logic need_vx;
        logic blk_store;
        logic blk_load;
        logic blk_last;
    } t_dp_stat;

    localparam logic [7:0] FONT [FONT_LEN] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    function automatic logic [7:0] font_byte(input logic [6:0] idx);
        return (32'(idx) < FONT_LEN) ? FONT[idx] : 8'h00;
    endfunction

endpackage

FILE: design/chip8_instruction_core_unit.sv
`timescale 1ns / 1ps
// channel  | dir | tdata fields (lsb first)                              | tuser
// s_axis   | in  | load_offset[11:0] load_byte[19:12] keys_down[35:20]   | cmd
//          |     | rand_byte[43:36], zero fill to 48 bits                |
// m_axis   | out | status[1:0] pc_now[13:2] opcode_done[29:14] draw[30]  | -
//          |     | delay_value[38:31] sound_value[46:39], zero fill to 48|
//
// a load word passes through take, load and finish; a step word through take, fetch hi,
// fetch lo, read y and execute, then a flag and/or register writeback and, for a block
// store/load, a read and a write step per register moved (x+1 registers), then finish.
// after reset a clearing pass writes font and zeros to every memory byte; no word is
// taken until it finishes. one result waits in the output register; the core takes the
// next word while it waits and stalls only when a second result is ready.
module chip8_instruction_core_unit #(
    parameter int MEM_BYTES   = 4096,
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // load_offset, load_byte, keys_down, rand_byte
    input  logic        i_s_axis_tuser,   // cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata    // status, pc_now, opcode_done, draw, delay, sound
);
    c8ic_pkg::t_dp_cmd  cmd;
    c8ic_pkg::t_dp_stat stat;

    logic [1:0]  status;
    logic [11:0] pc_now;
    logic [15:0] opcode_done;
    logic        draw;
    logic [7:0]  delay_value;
    logic [7:0]  sound_value;

    // sequencer: fetch, read, execute, writeback, block loops
    c8ic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_cmd    (i_s_axis_tuser),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // memories, cpu registers and result register
    c8ic_dpath #(
        .MEM_BYTES   (MEM_BYTES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_in_cmd      (i_s_axis_tuser),
        .i_load_offset (i_s_axis_tdata[11:0]),
        .i_load_byte   (i_s_axis_tdata[19:12]),
        .i_keys_down   (i_s_axis_tdata[35:20]),
        .i_rand_byte   (i_s_axis_tdata[43:36]),
        .o_status      (status),
        .o_pc_now      (pc_now),
        .o_opcode_done (opcode_done),
        .o_draw        (draw),
        .o_delay_value (delay_value),
        .o_sound_value (sound_value)
    );

    // upper tdata bits carry nothing
    logic [3:0] unused_tdata;
    assign unused_tdata = i_s_axis_tdata[47:44];

    assign o_m_axis_tdata = {1'b0, sound_value, delay_value, draw, opcode_done, pc_now,
                             status};
endmodule

FILE: design/c8ic_ram.sv
`timescale 1ns / 1ps
module c8ic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/c8ic_dpath.sv
`timescale 1ns / 1ps
module c8ic_dpath #(
    parameter int MEM_BYTES   = 4096,
    parameter int STACK_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  c8ic_pkg::t_dp_cmd   i_cmd,
    output c8ic_pkg::t_dp_stat  o_stat,
    input  logic                i_in_cmd,
    input  logic [11:0]         i_load_offset,
    input  logic [7:0]          i_load_byte,
    input  logic [15:0]         i_keys_down,
    input  logic [7:0]          i_rand_byte,
    output logic [1:0]          o_status,
    output logic [11:0]         o_pc_now,
    output logic [15:0]         o_opcode_done,
    output logic                o_draw,
    output logic [7:0]          o_delay_value,
    output logic [7:0]          o_sound_value
);
    localparam int AW  = $clog2(MEM_BYTES);
    localparam int SPW = $clog2(STACK_DEPTH);

    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SE   = 4'h3;
    localparam logic [3:0] OP_SNE  = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LDI  = 4'h6;
    localparam logic [3:0] OP_ADDI = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDIX = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] K_CLS = 8'hE0;
    localparam logic [7:0] K_RET = 8'hEE;
    localparam logic [3:0] K_SKP = 4'hE;
    localparam logic [3:0] K_SNP = 4'h1;
    localparam logic [7:0] F_GDT = 8'h07;
    localparam logic [7:0] F_WK  = 8'h0A;
    localparam logic [7:0] F_SDT = 8'h15;
    localparam logic [7:0] F_SST = 8'h18;
    localparam logic [7:0] F_ADI = 8'h1E;
    localparam logic [7:0] F_FNT = 8'h29;
    localparam logic [7:0] F_BCD = 8'h33;
    localparam logic [7:0] F_STO = 8'h55;
    localparam logic [7:0] F_LOD = 8'h65;
    localparam logic [3:0] VF    = 4'hF;

    // value modulo MEM_BYTES by conditional subtraction of shifted copies
    function automatic logic [AW-1:0] f_wrap(input logic [16:0] a);
        logic [23:0] r;
        r = 24'(a);
        for (int k = 6; k >= 0; k--) begin
            if (r >= (24'(MEM_BYTES) << k)) begin
                r = r - (24'(MEM_BYTES) << k);
            end
        end
        return r[AW-1:0];
    endfunction

    // architectural state
    logic [11:0]    r_pc;
    logic [15:0]    r_index;
    logic [SPW-1:0] r_sp;
    logic [11:0]    r_stack [STACK_DEPTH];
    logic [7:0]     r_dly;
    logic [7:0]     r_snd;
    logic [15:0]    r_vld;
    logic [AW-1:0]  r_clr;

    // per-item work registers
    logic           r_in_cmd;
    logic [11:0]    r_off;
    logic [7:0]     r_byte;
    logic [15:0]    r_keys;
    logic [7:0]     r_rand;
    logic [15:0]    r_op;
    logic [7:0]     r_vx;
    logic [7:0]     r_wvx;
    logic           r_wvf;
    logic [1:0]     r_status;
    logic           r_draw;
    logic [AW-1:0]  r_addr;
    logic [3:0]     r_cnt;
    logic           r_rvld;

    // result register
    logic [1:0]     r_o_status;
    logic [11:0]    r_o_pc;
    logic [15:0]    r_o_op;
    logic           r_o_draw;
    logic [7:0]     r_o_dly;
    logic [7:0]     r_o_snd;

    // memory ports
    logic           m_we;
    logic [AW-1:0]  m_waddr;
    logic [7:0]     m_wdata;
    logic [AW-1:0]  m_raddr;
    logic [7:0]     m_rdata;
    logic           g_we;
    logic [3:0]     g_waddr;
    logic [7:0]     g_wdata;
    logic [3:0]     g_raddr;
    logic [7:0]     g_rdata;
    logic [7:0]     reg_rd;

    logic [12:0]    ld_addr;
    logic           ld_ok;

    c8ic_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    c8ic_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    assign reg_rd  = r_rvld ? g_rdata : 8'h00;
    assign ld_addr = {1'b0, r_off} + c8ic_pkg::PROG_BASE;
    assign ld_ok   = ld_addr < 13'(MEM_BYTES);

    // memory port steering
    always_comb begin
        m_we    = 1'b0;
        m_waddr = r_addr;
        m_wdata = reg_rd;
        m_raddr = r_addr;
        g_we    = 1'b0;
        g_waddr = r_cnt;
        g_wdata = m_rdata;
        g_raddr = r_cnt;
        unique case (i_cmd.op)
            c8ic_pkg::DP_CLEAR: begin
                m_we    = 1'b1;
                m_waddr = r_clr;
                m_wdata = (32'(r_clr) < c8ic_pkg::FONT_LEN) ?
                          c8ic_pkg::font_byte(r_clr[6:0]) : 8'h00;
            end
            c8ic_pkg::DP_LOAD: begin
                m_we    = ld_ok;
                m_waddr = ld_addr[AW-1:0];
                m_wdata = r_byte;
            end
            c8ic_pkg::DP_FETCH_HI: m_raddr = f_wrap(17'(r_pc));
            c8ic_pkg::DP_FETCH_LO: begin
                m_raddr = f_wrap(17'(r_pc) + 17'd1);
                g_raddr = m_rdata[3:0];
            end
            c8ic_pkg::DP_READ_Y: begin
                // jump with offset reads V0 in the y slot
                g_raddr = (r_op[15:12] == OP_JPV0) ? 4'h0 : m_rdata[7:4];
            end
            c8ic_pkg::DP_WR_VF: begin
                g_we    = 1'b1;
                g_waddr = VF;
                g_wdata = {7'b0, r_wvf};
            end
            c8ic_pkg::DP_WR_VX: begin
                g_we    = 1'b1;
                g_waddr = r_op[11:8];
                g_wdata = r_wvx;
            end
            c8ic_pkg::DP_ST_RD: g_raddr = r_cnt;
            c8ic_pkg::DP_ST_WR: m_we = 1'b1;
            c8ic_pkg::DP_LD_RD: m_raddr = r_addr;
            c8ic_pkg::DP_LD_WR: g_we = 1'b1;
            default: ;
        endcase
    end

    // instruction decode and execute
    logic [3:0]     ex_hi, ex_lo, ex_x;
    logic [7:0]     ex_kk, ex_vy;
    logic [11:0]    ex_nnn, ex_next2, ex_next4;
    logic [8:0]     ex_sum;
    logic           ex_pressed;
    logic [SPW-1:0] ex_sp_inc, ex_sp_dec;
    logic [11:0]    n_pc;
    logic [SPW-1:0] n_sp;
    logic           n_push;
    logic [15:0]    n_index;
    logic [7:0]     n_dly, n_snd, n_wvx;
    logic           n_wvf, n_draw;
    logic [1:0]     n_status;
    logic           alu_flag, alu_wr;

    assign ex_hi    = r_op[15:12];
    assign ex_x     = r_op[11:8];
    assign ex_lo    = r_op[3:0];
    assign ex_kk    = r_op[7:0];
    assign ex_nnn   = r_op[11:0];
    assign ex_vy    = reg_rd;
    assign ex_next2 = r_pc + 12'd2;
    assign ex_next4 = r_pc + 12'd4;
    assign ex_sum   = {1'b0, r_vx} + {1'b0, ex_vy};
    assign ex_pressed = (r_vx[7:4] == 4'h0) && r_keys[r_vx[3:0]];
    assign ex_sp_inc = (r_sp == SPW'(STACK_DEPTH - 1)) ? '0 : r_sp + 1'b1;
    assign ex_sp_dec = (r_sp == '0) ? SPW'(STACK_DEPTH - 1) : r_sp - 1'b1;

    assign alu_flag = (ex_lo == ALU_ADD) || (ex_lo == ALU_SUB) || (ex_lo == ALU_SHR) ||
                      (ex_lo == ALU_SBN) || (ex_lo == ALU_SHL);
    assign alu_wr   = alu_flag || (ex_lo == ALU_MOV) || (ex_lo == ALU_OR) ||
                      (ex_lo == ALU_AND) || (ex_lo == ALU_XOR);

    always_comb begin
        n_pc     = ex_next2;
        n_sp     = r_sp;
        n_push   = 1'b0;
        n_index  = r_index;
        n_dly    = r_dly;
        n_snd    = r_snd;
        n_wvx    = r_vx;
        n_wvf    = 1'b0;
        n_draw   = 1'b0;
        n_status = c8ic_pkg::ST_OK;
        unique case (ex_hi)
            OP_SYS: begin
                if (ex_kk == K_CLS) begin
                    n_draw = 1'b1;
                end else if (ex_kk == K_RET) begin
                    n_pc = r_stack[r_sp];
                    n_sp = ex_sp_dec;
                end
            end
            OP_JP:   n_pc = ex_nnn;
            OP_CALL: begin
                n_sp   = ex_sp_inc;
                n_push = 1'b1;
                n_pc   = ex_nnn;
            end
            OP_SE:   n_pc = (r_vx == ex_kk) ? ex_next4 : ex_next2;
            OP_SNE:  n_pc = (r_vx != ex_kk) ? ex_next4 : ex_next2;
            OP_SER:  n_pc = (r_vx == ex_vy) ? ex_next4 : ex_next2;
            OP_LDI:  n_wvx = ex_kk;
            OP_ADDI: n_wvx = r_vx + ex_kk;
            OP_ALU: begin
                unique case (ex_lo)
                    ALU_MOV: n_wvx = ex_vy;
                    ALU_OR:  n_wvx = r_vx | ex_vy;
                    ALU_AND: n_wvx = r_vx & ex_vy;
                    ALU_XOR: n_wvx = r_vx ^ ex_vy;
                    ALU_ADD: begin
                        n_wvf = ex_sum[8];
                        n_wvx = ex_sum[7:0];
                    end
                    ALU_SUB: begin
                        n_wvf = r_vx > ex_vy;
                        n_wvx = r_vx - ex_vy;
                    end
                    ALU_SHR: begin
                        n_wvf = r_vx[0];
                        n_wvx = {1'b0, r_vx[7:1]};
                    end
                    ALU_SBN: begin
                        n_wvf = ex_vy > r_vx;
                        n_wvx = ex_vy - r_vx;
                    end
                    ALU_SHL: begin
                        n_wvf = r_vx[7];
                        n_wvx = {r_vx[6:0], 1'b0};
                    end
                    default: ;
                endcase
            end
            OP_SNER: n_pc = (r_vx != ex_vy) ? ex_next4 : ex_next2;
            OP_LDIX: n_index = {4'h0, ex_nnn};
            OP_JPV0: n_pc = ex_nnn + {4'h0, ex_vy};
            OP_RND:  n_wvx = r_rand & ex_kk;
            OP_KEY: begin
                if ((ex_lo == K_SKP && ex_pressed) || (ex_lo == K_SNP && !ex_pressed)) begin
                    n_pc = ex_next4;
                end
            end
            OP_MISC: begin
                unique case (ex_kk)
                    F_GDT: n_wvx = r_dly;
                    F_SDT: n_dly = r_vx;
                    F_SST: n_snd = r_vx;
                    F_ADI: n_index = r_index + {8'h00, r_vx};
                    F_WK, F_FNT, F_BCD, F_STO, F_LOD: ;
                    default: begin
                        n_status = c8ic_pkg::ST_BAD_FX;
                        n_pc     = r_pc;
                    end
                endcase
            end
            default: ;  // draw advances pc only
        endcase
    end

    always_comb begin
        o_stat.clr_last  = r_clr == AW'(MEM_BYTES - 1);
        o_stat.need_vf   = (ex_hi == OP_ALU) && alu_flag;
        o_stat.need_vx   = (ex_hi == OP_LDI) || (ex_hi == OP_ADDI) || (ex_hi == OP_RND) ||
                           ((ex_hi == OP_ALU) && alu_wr) ||
                           ((ex_hi == OP_MISC) && (ex_kk == F_GDT));
        o_stat.blk_store = (ex_hi == OP_MISC) && (ex_kk == F_STO);
        o_stat.blk_load  = (ex_hi == OP_MISC) && (ex_kk == F_LOD);
        o_stat.blk_last  = r_cnt == ex_x;
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= c8ic_pkg::PC_RESET;
            r_index <= '0;
            r_sp    <= '0;
            r_dly   <= '0;
            r_snd   <= '0;
            r_vld   <= '0;
            r_clr   <= '0;
            for (int s = 0; s < STACK_DEPTH; s++) begin
                r_stack[s] <= '0;
            end
        end else begin
            if (i_cmd.op == c8ic_pkg::DP_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (g_we) begin
                r_vld[g_waddr] <= 1'b1;
            end
            if (i_cmd.op == c8ic_pkg::DP_EXEC) begin
                r_pc    <= n_pc;
                r_sp    <= n_sp;
                r_index <= n_index;
                r_dly   <= n_dly;
                r_snd   <= n_snd;
                if (n_push) begin
                    r_stack[n_sp] <= ex_next2;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rvld <= r_vld[g_raddr];
        unique case (i_cmd.op)
            c8ic_pkg::DP_TAKE: begin
                r_in_cmd <= i_in_cmd;
                r_off    <= i_load_offset;
                r_byte   <= i_load_byte;
                r_keys   <= i_keys_down;
                r_rand   <= i_rand_byte;
                r_op     <= '0;
                r_status <= c8ic_pkg::ST_OK;
                r_draw   <= 1'b0;
            end
            c8ic_pkg::DP_LOAD: begin
                if (!ld_ok) begin
                    r_status <= c8ic_pkg::ST_LOAD_OVF;
                end
            end
            c8ic_pkg::DP_FETCH_LO: r_op[15:8] <= m_rdata;
            c8ic_pkg::DP_READ_Y: begin
                r_op[7:0] <= m_rdata;
                r_vx      <= reg_rd;
            end
            c8ic_pkg::DP_EXEC: begin
                r_wvx    <= n_wvx;
                r_wvf    <= n_wvf;
                r_status <= n_status;
                r_draw   <= n_draw;
                r_addr   <= f_wrap({1'b0, r_index});
                r_cnt    <= '0;
            end
            c8ic_pkg::DP_ST_WR, c8ic_pkg::DP_LD_WR: begin
                r_cnt  <= r_cnt + 1'b1;
                r_addr <= (r_addr == AW'(MEM_BYTES - 1)) ? '0 : r_addr + 1'b1;
            end
            default: ;
        endcase
        if (i_cmd.publish) begin
            r_o_status <= r_status;
            r_o_pc     <= r_pc;
            r_o_op     <= r_op;
            r_o_draw   <= r_draw;
            r_o_dly    <= r_dly;
            r_o_snd    <= r_snd;
        end
    end

    assign o_status      = r_o_status;
    assign o_pc_now      = r_o_pc;
    assign o_opcode_done = r_o_op;
    assign o_draw        = r_o_draw;
    assign o_delay_value = r_o_dly;
    assign o_sound_value = r_o_snd;

    // r_in_cmd is captured with each word but not used
    logic unused_in_cmd;
    assign unused_in_cmd = r_in_cmd;
endmodule

FILE: design/c8ic_ctrl.sv
`timescale 1ns / 1ps
module c8ic_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_in_cmd,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output c8ic_pkg::t_dp_cmd  o_cmd,
    input  c8ic_pkg::t_dp_stat i_stat
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_FHI, S_FLO, S_RDY, S_EXEC,
        S_WVF, S_WVX, S_STR, S_STW, S_LDR, S_LDW, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   in_acc, out_free;

    assign o_in_ready  = r_state == S_IDLE;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = c8ic_pkg::DP_NONE;
        o_cmd.publish = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = c8ic_pkg::DP_CLEAR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.op = c8ic_pkg::DP_TAKE;
                    n_state  = i_in_cmd ? S_LOAD : S_FHI;
                end
            end
            S_LOAD: begin
                o_cmd.op = c8ic_pkg::DP_LOAD;
                n_state  = S_FIN;
            end
            S_FHI: begin
                o_cmd.op = c8ic_pkg::DP_FETCH_HI;
                n_state  = S_FLO;
            end
            S_FLO: begin
                o_cmd.op = c8ic_pkg::DP_FETCH_LO;
                n_state  = S_RDY;
            end
            S_RDY: begin
                o_cmd.op = c8ic_pkg::DP_READ_Y;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.op = c8ic_pkg::DP_EXEC;
                priority if (i_stat.need_vf) n_state = S_WVF;
                else if (i_stat.need_vx)     n_state = S_WVX;
                else if (i_stat.blk_store)   n_state = S_STR;
                else if (i_stat.blk_load)    n_state = S_LDR;
                else                         n_state = S_FIN;
            end
            S_WVF: begin
                o_cmd.op = c8ic_pkg::DP_WR_VF;
                n_state  = i_stat.need_vx ? S_WVX : S_FIN;
            end
            S_WVX: begin
                o_cmd.op = c8ic_pkg::DP_WR_VX;
                n_state  = S_FIN;
            end
            S_STR: begin
                o_cmd.op = c8ic_pkg::DP_ST_RD;
                n_state  = S_STW;
            end
            S_STW: begin
                o_cmd.op = c8ic_pkg::DP_ST_WR;
                n_state  = i_stat.blk_last ? S_FIN : S_STR;
            end
            S_LDR: begin
                o_cmd.op = c8ic_pkg::DP_LD_RD;
                n_state  = S_LDW;
            end
            S_LDW: begin
                o_cmd.op = c8ic_pkg::DP_LD_WR;
                n_state  = i_stat.blk_last ? S_FIN : S_LDR;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("word taken during memory clear");

    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a pending word");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready && !o_cmd.publish)
        else $error("accept did not start work");
endmodule
